>>> hw/rtl/rmpg_pkg.sv
// Shared constants, register map and types of the rainbow matrix pixel generator.
package rmpg_pkg;

  localparam int unsigned ROWS = 8;
  localparam int unsigned COLS = 8;
  localparam int unsigned PIXELS = ROWS * COLS;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned X_W = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);
  localparam logic [X_W-1:0] LAST_X = X_W'(COLS - 1);

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_SATURATION  = 3'd0;
  localparam logic [2:0] REG_VALUE_LEVEL = 3'd1;
  localparam logic [2:0] REG_COL_STEP    = 3'd2;
  localparam logic [2:0] REG_ROW_STEP    = 3'd3;
  localparam logic [2:0] REG_FRAME_STEP  = 3'd4;

  localparam logic [7:0] RST_SATURATION  = 8'd255;
  localparam logic [7:0] RST_VALUE_LEVEL = 8'd150;
  localparam logic [7:0] RST_COL_STEP    = 8'd32;
  localparam logic [7:0] RST_ROW_STEP    = 8'd16;
  localparam logic [7:0] RST_FRAME_STEP  = 8'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic       start;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_req_t;

endpackage

>>> hw/rtl/rainbow_matrix_pixel_generator_unit.sv
// Each transaction with frame_request set streams one colour per matrix pixel, row by row.
// Each pixel goes through the start state, the conversion and then the output register.
// Pixels are converted one at a time, each by five passes through the one shared 8x8
// multiplier of the HSV converter; a new frame request is taken only while idle.
// A request with frame_request clear is taken while idle and emits nothing.
// Reset (asynchronous, active low) restores the register defaults and a zero hue offset.
module rainbow_matrix_pixel_generator_unit
  import rmpg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Frame requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [0] frame_request, [7:1] zero
  // Pixel stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // [5:0] pixel_index, [13:6] red, [21:14] green,
                                           // [29:22] blue, [31:30] zero
  output logic              m_axis_tlast   // last_pixel
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_CONV  = 2'd2;
  localparam logic [1:0] ST_PUT   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [7:0]       sat_q, val_q, col_step_q, row_step_q, frame_step_q;
  logic [7:0]       hue_base_q;
  logic [7:0]       col_hue_q, row_hue_q;
  logic [X_W-1:0]   x_q;
  logic [IDX_W-1:0] idx_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  rgb_t             out_rgb_q;
  logic             out_last_q;

  logic             cfg_wr;
  logic [2:0]       reg_idx;
  logic             in_take;
  logic             load;
  logic             frame_end;
  hsv_req_t         hsv_req;
  logic             hsv_done;
  rgb_t             hsv_rgb;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SATURATION:  prdata[7:0] = sat_q;
      REG_VALUE_LEVEL: prdata[7:0] = val_q;
      REG_COL_STEP:    prdata[7:0] = col_step_q;
      REG_ROW_STEP:    prdata[7:0] = row_step_q;
      REG_FRAME_STEP:  prdata[7:0] = frame_step_q;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q        <= RST_SATURATION;
      val_q        <= RST_VALUE_LEVEL;
      col_step_q   <= RST_COL_STEP;
      row_step_q   <= RST_ROW_STEP;
      frame_step_q <= RST_FRAME_STEP;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SATURATION:  sat_q        <= pwdata[7:0];
        REG_VALUE_LEVEL: val_q        <= pwdata[7:0];
        REG_COL_STEP:    col_step_q   <= pwdata[7:0];
        REG_ROW_STEP:    row_step_q   <= pwdata[7:0];
        REG_FRAME_STEP:  frame_step_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  // The output register may still hold a pixel while the next one is being converted.
  assign load          = (state_q == ST_PUT) && (!out_valid_q || m_axis_tready);
  assign frame_end     = load && (idx_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_take && s_axis_tdata[0]) state_d = ST_START;
      ST_START: state_d = ST_CONV;
      ST_CONV:  if (hsv_done) state_d = ST_PUT;
      ST_PUT:   if (load) state_d = frame_end ? ST_IDLE : ST_START;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hue_base_q  <= '0;
      x_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take && s_axis_tdata[0]) begin
        x_q   <= '0;
        idx_q <= '0;
      end else if (load) begin
        idx_q <= idx_q + 1'b1;
        x_q   <= (x_q == LAST_X) ? '0 : x_q + 1'b1;
      end
      if (frame_end) hue_base_q <= hue_base_q + frame_step_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      col_hue_q <= hue_base_q;
      row_hue_q <= hue_base_q;
    end else if (load) begin
      if (x_q == LAST_X) begin
        row_hue_q <= row_hue_q + row_step_q;
        col_hue_q <= row_hue_q + row_step_q;
      end else begin
        col_hue_q <= col_hue_q + col_step_q;
      end
    end
    if (load) begin
      out_idx_q  <= idx_q;
      out_rgb_q  <= hsv_rgb;
      out_last_q <= (idx_q == LAST_IDX);
    end
  end

  assign hsv_req = '{start: (state_q == ST_START), hue: col_hue_q, sat: sat_q, val: val_q};

  rmpg_hsv u_hsv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hsv_req),
    .done_o (hsv_done),
    .rgb_o  (hsv_rgb)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red, out_idx_q};
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // A frame-ending pixel always carries the final index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[IDX_W-1:0] == LAST_IDX))
    else $error("last pixel flagged on a wrong index");

  // The converter only finishes while a conversion is awaited.
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_done |-> (state_q == ST_CONV))
    else $error("converter finished outside a conversion");

  // A real frame request starts a conversion at once and blocks further requests.
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && s_axis_tdata[0]) |=> ((state_q == ST_START) && !s_axis_tready))
    else $error("frame request did not start a conversion");
`endif

endmodule

>>> hw/rtl/rmpg_hsv.sv
// Iterative 8-bit HSV to RGB converter built around one shared 8x8 multiplier.
module rmpg_hsv
  import rmpg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hsv_req_t req_i,
  output logic     done_o,
  output rgb_t     rgb_o
);

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_QS   = 3'd1;
  localparam logic [2:0] STEP_TS   = 3'd2;
  localparam logic [2:0] STEP_P    = 3'd3;
  localparam logic [2:0] STEP_Q    = 3'd4;
  localparam logic [2:0] STEP_T    = 3'd5;

  localparam logic [7:0] HUE_DIV = 8'd43;

  logic [2:0]  step_q, step_d;
  logic [2:0]  region_q, region_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  qs_q, ts_q, p_q, q_q;
  logic        done_q;
  rgb_t        rgb_q, rgb_d;

  logic [7:0]  base;
  logic [7:0]  diff;
  logic [7:0]  mul_a, mul_b;
  logic [15:0] prod;
  logic [7:0]  hi;

  // Region is hue/43; the five thresholds are multiples of 43.
  always_comb begin
    priority if (req_i.hue >= 8'd215) begin
      region_d = 3'd5;
    end else if (req_i.hue >= 8'd172) begin
      region_d = 3'd4;
    end else if (req_i.hue >= 8'd129) begin
      region_d = 3'd3;
    end else if (req_i.hue >= 8'd86) begin
      region_d = 3'd2;
    end else if (req_i.hue >= HUE_DIV) begin
      region_d = 3'd1;
    end else begin
      region_d = 3'd0;
    end
    base  = 8'(region_d * HUE_DIV);
    diff  = req_i.hue - base;
    rem_d = 8'({diff, 2'b00} + {diff, 1'b0});
  end

  // Operand selection for the shared multiplier; 255 - x is the complement.
  always_comb begin
    unique case (step_q)
      STEP_QS: begin
        mul_a = req_i.sat;
        mul_b = rem_q;
      end
      STEP_TS: begin
        mul_a = req_i.sat;
        mul_b = ~rem_q;
      end
      STEP_P: begin
        mul_a = req_i.val;
        mul_b = ~req_i.sat;
      end
      STEP_Q: begin
        mul_a = req_i.val;
        mul_b = qs_q;
      end
      STEP_T: begin
        mul_a = req_i.val;
        mul_b = ts_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign hi   = prod[15:8];

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      STEP_IDLE: if (req_i.start) step_d = STEP_QS;
      STEP_QS:   step_d = STEP_TS;
      STEP_TS:   step_d = STEP_P;
      STEP_P:    step_d = STEP_Q;
      STEP_Q:    step_d = STEP_T;
      STEP_T:    step_d = STEP_IDLE;
      default:   step_d = STEP_IDLE;
    endcase
  end

  // Final pixel selection, taking t straight from the last product.
  always_comb begin
    if (req_i.sat == 8'd0) begin
      rgb_d = '{red: req_i.val, green: req_i.val, blue: req_i.val};
    end else begin
      unique case (region_q)
        3'd0:    rgb_d = '{red: req_i.val, green: hi,        blue: p_q};
        3'd1:    rgb_d = '{red: q_q,       green: req_i.val, blue: p_q};
        3'd2:    rgb_d = '{red: p_q,       green: req_i.val, blue: hi};
        3'd3:    rgb_d = '{red: p_q,       green: q_q,       blue: req_i.val};
        3'd4:    rgb_d = '{red: hi,        green: p_q,       blue: req_i.val};
        default: rgb_d = '{red: req_i.val, green: p_q,       blue: q_q};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == STEP_T);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == STEP_IDLE && req_i.start) begin
      region_q <= region_d;
      rem_q    <= rem_d;
    end
    if (step_q == STEP_QS) qs_q <= ~hi;
    if (step_q == STEP_TS) ts_q <= ~hi;
    if (step_q == STEP_P)  p_q  <= hi;
    if (step_q == STEP_Q)  q_q  <= hi;
    if (step_q == STEP_T)  rgb_q <= rgb_d;
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

endmodule

>>> dv/rainbow_matrix_pixel_generator_unit_tb.sv
// Self-checking testbench for the rainbow matrix pixel generator.
module rainbow_matrix_pixel_generator_unit_tb;
  import rmpg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {ROW_WRITE, ROW_FRAME, ROW_GREY} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    logic        req;
    logic [7:0]  grey;
  } script_row_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    rgb_t             colour;
    logic             last;
  } pixel_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // [0] frame_request, [7:1] zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [5:0] pixel_index, [13:6] red, [21:14] green,
                                          // [29:22] blue, [31:30] zero
  logic              m_axis_tlast;        // last_pixel

  rainbow_matrix_pixel_generator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the register file and the frame-to-frame hue offset.
  logic [7:0] cfg_sat = 8'd255;
  logic [7:0] cfg_val = 8'd150;
  logic [7:0] cfg_col = 8'd32;
  logic [7:0] cfg_row = 8'd16;
  logic [7:0] cfg_frame = 8'd2;
  logic [7:0] hue_base = 8'd0;

  pixel_t      pending_pixels[$];
  int unsigned error_count = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_wait = 0;

  script_row_t script[] = '{
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b0, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_WRITE, REG_SATURATION,  32'd0,          1'b0, 8'd0},
    '{ROW_WRITE, REG_VALUE_LEVEL, 32'd255,        1'b0, 8'd0},
    '{ROW_GREY,  REG_SATURATION,  32'd0,          1'b1, 8'd255},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b0, 8'd0},
    '{ROW_WRITE, REG_VALUE_LEVEL, 32'd0,          1'b0, 8'd0},
    '{ROW_GREY,  REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_WRITE, REG_SATURATION,  32'd255,        1'b0, 8'd0},
    '{ROW_GREY,  REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_WRITE, REG_VALUE_LEVEL, 32'd255,        1'b0, 8'd0},
    '{ROW_WRITE, REG_COL_STEP,    32'd43,         1'b0, 8'd0},
    '{ROW_WRITE, REG_ROW_STEP,    32'd1,          1'b0, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_WRITE, REG_COL_STEP,    32'd255,        1'b0, 8'd0},
    '{ROW_WRITE, REG_ROW_STEP,    32'd255,        1'b0, 8'd0},
    '{ROW_WRITE, REG_FRAME_STEP,  32'd255,        1'b0, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    // Writes to the unmapped indexes above the register file must change nothing.
    '{ROW_WRITE, REG_FRAME_STEP + 3'd1, 32'd0,        1'b0, 8'd0},
    '{ROW_WRITE, REG_FRAME_STEP + 3'd2, 32'hff,       1'b0, 8'd0},
    '{ROW_WRITE, REG_FRAME_STEP + 3'd3, 32'hffff_ffff, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SATURATION,  32'hffff_ff80,   1'b0, 8'd0},
    '{ROW_WRITE, REG_VALUE_LEVEL, 32'h0000_0101,   1'b0, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_WRITE, REG_SATURATION,  32'd1,          1'b0, 8'd0},
    '{ROW_WRITE, REG_VALUE_LEVEL, 32'd200,        1'b0, 8'd0},
    '{ROW_WRITE, REG_COL_STEP,    32'd0,          1'b0, 8'd0},
    '{ROW_WRITE, REG_ROW_STEP,    32'd7,          1'b0, 8'd0},
    '{ROW_WRITE, REG_FRAME_STEP,  32'd0,          1'b0, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b1, 8'd0},
    '{ROW_FRAME, REG_SATURATION,  32'd0,          1'b0, 8'd0}
  };

  function automatic rgb_t hsv_colour(logic [7:0] hue, logic [7:0] sat, logic [7:0] val);
    int unsigned h, s, v, region, rem, p, q, t;
    rgb_t        c;
    h = hue;
    s = sat;
    v = val;
    if (s == 0) begin
      c.red = val;
      c.green = val;
      c.blue = val;
      return c;
    end
    region = h / 43;
    rem = ((h - region * 43) * 6) & 8'hff;
    p = (v * (255 - s)) >> 8;
    q = (v * (255 - ((s * rem) >> 8))) >> 8;
    t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
    case (region)
      0: begin
        c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
      end
      1: begin
        c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
      end
      2: begin
        c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
      end
      3: begin
        c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
      end
      4: begin
        c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
      end
      default: begin
        c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
      end
    endcase
    return c;
  endfunction

  // Queues the colours of one whole frame; a typed grey replaces the computed colour.
  function automatic void render_frame(bit use_grey, logic [7:0] grey);
    pixel_t      px;
    int unsigned pos;
    logic [7:0]  hue;
    for (int unsigned y = 0; y < ROWS; y++) begin
      for (int unsigned x = 0; x < COLS; x++) begin
        pos = y * COLS + x;
        hue = 8'(hue_base + x * cfg_col + y * cfg_row);
        px.index = IDX_W'(pos);
        px.last = (pos == PIXELS - 1);
        if (use_grey) begin
          px.colour.red = grey;
          px.colour.green = grey;
          px.colour.blue = grey;
        end else begin
          px.colour = hsv_colour(hue, cfg_sat, cfg_val);
        end
        pending_pixels.push_back(px);
      end
    end
    hue_base = hue_base + cfg_frame;
  endfunction

  function automatic void take_pixel(logic [31:0] data, logic last);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected pixel idx %0d rgb %02x %02x %02x last %0b", $time,
               data[5:0], data[13:6], data[21:14], data[29:22], last);
      error_count++;
      return;
    end
    want = pending_pixels.pop_front();
    if (data[5:0] !== want.index || data[13:6] !== want.colour.red ||
        data[21:14] !== want.colour.green || data[29:22] !== want.colour.blue ||
        last !== want.last) begin
      $display({"%0t: pixel mismatch: expected idx %0d rgb %02x %02x %02x last %0b, ",
                "got idx %0d rgb %02x %02x %02x last %0b"},
               $time, want.index, want.colour.red, want.colour.green, want.colour.blue,
               want.last, data[5:0], data[13:6], data[21:14], data[29:22], last);
      error_count++;
    end
  endfunction

  // Pixel sink: checks every transaction and then holds tready low for a randomly drawn stall, none in steady phases.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      take_pixel(m_axis_tdata, m_axis_tlast);
      rx_wait = rx_steady ? 0 : $urandom_range(0, 15);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    m_axis_tready <= (rx_wait == 0);
  end

  task automatic apb_access(logic write, logic [2:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] register_value(logic [2:0] idx);
    case (idx)
      REG_SATURATION:  return cfg_sat;
      REG_VALUE_LEVEL: return cfg_val;
      REG_COL_STEP:    return cfg_col;
      REG_ROW_STEP:    return cfg_row;
      default:         return cfg_frame;
    endcase
  endfunction

  task automatic read_back(logic [2:0] idx);
    logic [31:0] got;
    apb_access(1'b0, idx, 32'd0, got);
    if (got !== {24'd0, register_value(idx)}) begin
      $display("%0t: register %0d read mismatch: expected %08x, got %08x", $time, idx,
               {24'd0, register_value(idx)}, got);
      error_count++;
    end
  endtask

  task automatic set_register(logic [2:0] idx, logic [31:0] data);
    logic [31:0] unused;
    apb_access(1'b1, idx, data, unused);
    case (idx)
      REG_SATURATION:  cfg_sat = data[7:0];
      REG_VALUE_LEVEL: cfg_val = data[7:0];
      REG_COL_STEP:    cfg_col = data[7:0];
      REG_ROW_STEP:    cfg_row = data[7:0];
      REG_FRAME_STEP:  cfg_frame = data[7:0];
      default: ;
    endcase
    if (idx <= REG_FRAME_STEP) read_back(idx);
  endtask

  // Stops requesting, lets the frame in flight finish and gives a request with no pixels
  // time to clear before the registers are touched.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic send_request(logic req, bit use_grey, logic [7:0] grey);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {7'd0, req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (req) render_frame(use_grey, grey);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned frames;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i <= REG_FRAME_STEP; i++) read_back(3'(i));

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_WRITE: begin
          wait_drain();
          set_register(script[i].reg_idx, script[i].data);
        end
        ROW_GREY:  send_request(1'b1, 1'b1, script[i].grey);
        default:   send_request(script[i].req, 1'b0, 8'd0);
      endcase
    end

    for (int phase = 0; phase < 8; phase++) begin
      wait_drain();
      tx_steady = (phase % 3 == 1);
      rx_steady = (phase % 3 == 2);
      // The first two phases put every register at an extreme, the rest mix extremes in.
      for (int r = 0; r <= REG_FRAME_STEP; r++) begin
        if (phase == 0) set_register(3'(r), 32'hff);
        else if (phase == 1) set_register(3'(r), 32'd0);
        else set_register(3'(r), {$urandom_range(0, 1) ? 24'hffffff : 24'd0, pick_byte()});
      end
      if ($urandom_range(0, 1)) set_register(3'($urandom_range(REG_FRAME_STEP + 1, 7)), $urandom);
      frames = 0;
      while (frames < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(1'b0, 1'b0, 8'd0);
        end else begin
          send_request(1'b1, 1'b0, 8'd0);
          frames++;
        end
        if ($urandom_range(0, 39) == 0) wait_drain();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS rainbow_matrix_pixel_generator_unit");
    end else begin
      $display("FAIL rainbow_matrix_pixel_generator_unit");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL rainbow_matrix_pixel_generator_unit");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rmpg_pkg.sv
hw/rtl/rmpg_hsv.sv
hw/rtl/rainbow_matrix_pixel_generator_unit.sv
dv/rainbow_matrix_pixel_generator_unit_tb.sv
